@@ rtl/core/psfr_pkg.sv @@
// Shared types, constants and functions for the peak smoothing framed reporter.
// No dependencies; psfr_front, psfr_back and the top level import this package.
package psfr_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_REPORT = 2'd1,
        OP_TEST   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_COMMIT = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd_kind;

    localparam int          QUEUE_DEPTH   = 4;
    localparam int          TEST_LEN      = 22;
    localparam logic [2:0]  LIGHT_SLOT    = 3'd3;
    localparam logic [7:0]  TOOL_RESET    = 8'hC8;
    localparam logic [7:0]  CHECK_POLY    = 8'h3C;

    function automatic logic [7:0] check_step(input logic [7:0] c, input logic [7:0] v);
        logic [7:0] x;
        logic [7:0] r;
        x = c ^ v;
        r = {x[0], x[7:1]};
        if (r[7]) begin
            r = r ^ CHECK_POLY;
        end
        return r;
    endfunction

    function automatic logic [7:0] test_byte(input logic [4:0] idx, input logic [7:0] tool);
        logic [7:0] b;
        unique case (idx)
            5'd0:  b = 8'd20;
            5'd1:  b = 8'h00;
            5'd2:  b = 8'hAA;
            5'd3:  b = 8'hC0;
            5'd4:  b = 8'h55;
            5'd5:  b = 8'h3F;
            5'd6:  b = 8'h31;
            5'd7:  b = 8'hF7;
            5'd8:  b = 8'h00;
            5'd9:  b = 8'h80;
            5'd10: b = 8'h00;
            5'd11: b = 8'h00;
            5'd12: b = 8'hFF;
            5'd13: b = 8'hFF;
            5'd14: b = 8'hCE;
            5'd15: b = 8'h08;
            5'd16: b = tool;
            5'd17: b = tool;
            5'd18: b = 8'h02;
            5'd19: b = 8'h01;
            5'd20: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/psfr_queue.sv @@
// Short first-word-fall-through command queue between the front and back parts.
// Depends on nothing but its parameters.
module psfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/core/psfr_front.sv @@
// Front part: accepts input words, tracks the burst peak and queues commands.
// Depends on psfr_pkg.
module psfr_front #(
    parameter int SLOTS       = 6,
    parameter int SAMPLE_BITS = 10,
    parameter int CMD_W       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_op,
    input  logic [2:0]       i_slot,
    input  logic [9:0]       i_sample,
    input  logic             i_first,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_q_push,
    output logic [CMD_W-1:0] o_q_data
);
    import psfr_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [SAMPLE_BITS-1:0] samp;
    logic [4:0]             slot_ext;
    logic                   slot_ok;
    logic                   accept;
    t_op                    op;
    t_cmd_kind              kind;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign op       = t_op'(i_op);
    assign samp     = SAMPLE_BITS'(i_sample);
    assign slot_ext = {2'b00, i_slot};
    assign slot_ok  = (i_slot != 3'd0) && (slot_ext < 5'(SLOTS));

    always_comb begin
        n_peak   = r_peak;
        o_q_push = 1'b0;
        kind     = CMD_NONE;
        unique case (op)
            OP_SAMPLE: begin
                if (i_first || (samp > r_peak)) begin
                    n_peak = samp;
                end
                kind     = CMD_COMMIT;
                o_q_push = accept && i_last && slot_ok;
            end
            OP_REPORT: begin
                kind     = CMD_REPORT;
                o_q_push = accept;
            end
            OP_TEST: begin
                kind     = CMD_TEST;
                o_q_push = accept;
            end
            default: begin
                kind     = CMD_NONE;
            end
        endcase
    end

    assign o_q_data = {kind, (i_slot == LIGHT_SLOT), slot_ext[IDX_W-1:0], n_peak};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (accept) begin
            r_peak <= n_peak;
        end
    end

endmodule

@@ rtl/core/psfr_back.sv @@
// Back part: holds the smoothed values, applies commits and serializes frames.
// Depends on psfr_pkg.
module psfr_back #(
    parameter int SLOTS       = 6,
    parameter int SAMPLE_BITS = 10,
    parameter int CMD_W       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic [CMD_W-1:0] i_q_data,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last
);
    import psfr_pkg::*;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int SW        = SAMPLE_BITS;
    localparam int FRAME_MAX = (2 * SLOTS + 2 > TEST_LEN) ? (2 * SLOTS + 2) : TEST_LEN;
    localparam int CNT_W     = $clog2(FRAME_MAX);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REPORT = 3'b010,
        ST_TEST   = 3'b100
    } t_back_state;

    t_back_state     r_state;
    t_back_state     n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       r_csum;
    logic [7:0]       n_csum;
    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic [7:0]       n_byte;
    logic             r_last;
    logic             n_last;
    logic [7:0]       r_tool;
    logic [SW-1:0]    r_store [SLOTS];

    logic [1:0]       q_kind_raw;
    t_cmd_kind        q_kind;
    logic             q_light;
    logic [IDX_W-1:0] q_slot;
    logic [SW-1:0]    q_peak;
    logic             adv;
    logic [CNT_W-1:0] cnt_half;
    logic [IDX_W-1:0] word_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [SW-1:0]    rd_val;
    logic [15:0]      word;
    logic [7:0]       data_byte;
    logic [SW+1:0]    sum;
    logic [SW-1:0]    new_val;
    logic             commit_we;

    assign {q_kind_raw, q_light, q_slot, q_peak} = i_q_data;
    assign q_kind    = t_cmd_kind'(q_kind_raw);
    assign adv       = !r_valid || i_ready;
    assign cnt_half  = r_cnt >> 1;
    assign word_idx  = cnt_half[IDX_W-1:0];
    assign rd_idx    = (r_state == ST_IDLE) ? q_slot : word_idx;
    assign rd_val    = (32'(rd_idx) < SLOTS) ? r_store[rd_idx] : '0;
    assign word      = (word_idx == '0) ? 16'(2 * SLOTS) : 16'(rd_val);
    assign data_byte = r_cnt[0] ? word[15:8] : word[7:0];

    always_comb begin
        if (q_light) begin
            sum = (SW + 2)'(rd_val) + (SW + 2)'({rd_val, 1'b0}) + (SW + 2)'(q_peak);
        end else begin
            sum = (SW + 2)'(rd_val) + (SW + 2)'(q_peak) + (SW + 2)'({q_peak, 1'b0});
        end
    end
    assign new_val = sum[SW+1:2];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_csum    = r_csum;
        n_valid   = r_valid && !i_ready;
        n_byte    = r_byte;
        n_last    = r_last;
        o_q_pop   = 1'b0;
        commit_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    unique case (q_kind)
                        CMD_COMMIT: begin
                            commit_we = 1'b1;
                        end
                        CMD_REPORT: begin
                            n_state = ST_REPORT;
                            n_cnt   = '0;
                            n_csum  = '0;
                        end
                        CMD_TEST: begin
                            n_state = ST_TEST;
                            n_cnt   = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REPORT: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_last  = 1'b0;
                    if (r_cnt < CNT_W'(2 * SLOTS)) begin
                        n_byte = data_byte;
                        n_csum = check_step(r_csum, data_byte);
                    end else if (r_cnt == CNT_W'(2 * SLOTS)) begin
                        n_byte = r_csum;
                    end else begin
                        n_byte  = r_tool;
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TEST: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_byte  = test_byte(r_cnt[4:0], r_tool);
                    n_last  = (r_cnt == CNT_W'(TEST_LEN - 1));
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_csum  <= '0;
            r_valid <= 1'b0;
            r_tool  <= TOOL_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_csum  <= n_csum;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_tool <= i_cfg_wdata;
            end
            if (commit_we) begin
                r_store[q_slot] <= new_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

@@ rtl/core/peak_smoothing_framed_reporter.sv @@
// Top level of the peak smoothing framed reporter: front, command queue and back.
// Depends on psfr_pkg, psfr_front, psfr_queue and psfr_back.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata {sample, slot}, tuser {first_of_burst, op}, tlast last_of_burst
//  m_axis    out        tdata tx_byte, tlast frame_end
//  cfg       in         i_cfg_we / i_cfg_wdata write tool_code
//
// A sample is taken when accepted; a burst end to a valid slot also queues a commit for the back part.
// A report frame holds 2*SLOTS+2 bytes and a test frame 22, one byte per cycle while
// m_axis_tready allows it, paced by the single output register.
// The four-entry command queue lets samples flow while a frame drains or stalls.
// Reset is synchronous and active low and clears the peak and all smoothed values.
module peak_smoothing_framed_reporter #(
    parameter int SLOTS       = 6,
    parameter int SAMPLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] slot, [12:3] sample, [15:13] zero
    input  logic [2:0]  s_axis_tuser,   // [1:0] op, [2] first_of_burst
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import psfr_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMD_W = 2 + 1 + IDX_W + SAMPLE_BITS;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;

    psfr_front #(
        .SLOTS       (SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CMD_W       (CMD_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser[1:0]),
        .i_slot   (s_axis_tdata[2:0]),
        .i_sample (s_axis_tdata[12:3]),
        .i_first  (s_axis_tuser[2]),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    psfr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    psfr_back #(
        .SLOTS       (SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CMD_W       (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
